// File: rtl/core/rc_capacitance_meter_unit_assert.svh
// Assertion macros used by the checker module of the capacitance meter.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef RC_CAPACITANCE_METER_UNIT_ASSERT_SVH
`define RC_CAPACITANCE_METER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCCM_ASSERT_IMPLY(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("rc capacitance meter check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCCM_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("rc capacitance meter check failed");

`endif

// File: rtl/core/rccm_pkg.sv
// Package of the capacitance meter: field widths, codes, reset values and the result type.
// Depends on nothing; used by the top level and its checker.
package rccm_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int ADC_BITS_DEF   = 10;

    localparam int THR_W      = 10;
    localparam int PPT_W      = 24;
    localparam int REF_W      = 40;
    localparam int CALIB_W    = 24;
    localparam int CAL_FRAC_W = 16;
    localparam int CAP_W      = 40;
    localparam int DISP_W     = 21;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int UNIT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int DIV_W      = REF_W + CAL_FRAC_W;
    localparam int STEP_W     = $clog2(DIV_W);

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PF_PER_TICK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEASURE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CALIBRATE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MEAS_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAL_DONE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ERROR     = 2'd3;

    localparam logic [UNIT_W-1:0] UNIT_PF = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_NF = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_UF = 2'd2;

    localparam logic [THR_W-1:0]   HIGH_THR_RST = 10'd930;
    localparam logic [THR_W-1:0]   LOW_THR_RST  = 10'd310;
    localparam logic [PPT_W-1:0]   PPT_RST      = 24'd105917;
    localparam logic [REF_W-1:0]   REF_RST      = 40'd100000000;
    localparam logic [CALIB_W-1:0] CALIB_RST    = 24'd65536;

    localparam logic [CAP_W-1:0] SCALE_NANO  = 40'd1000;
    localparam logic [CAP_W-1:0] SCALE_MICRO = 40'd1000000;

    typedef struct packed {
        logic                charge_drive;
        logic [STATUS_W-1:0] status;
        logic [CAP_W-1:0]    cap_pf;
        logic [DISP_W-1:0]   display_value;
        logic [UNIT_W-1:0]   unit;
    } result_t;

endpackage

// File: rtl/core/rc_capacitance_meter_unit.sv
// Capacitance meter by RC timing, with a bit-serial multiplier and divider.
// Depends on rccm_pkg.
//
// Usage: the input channel carries one command per transaction (kind, sample): a
// start of measurement, a start of calibration, or a one-microsecond tick with an
// ADC sample. Every accepted transaction produces exactly one result transaction
// on the output channel (charge_drive, status, cap_pf, display_value, unit).
// Configuration registers are written through cfg_write, cfg_index and cfg_data;
// the user writes them only while the block is idle, which the block does not enforce.
// Flow: most commands give their result in the cycle after acceptance, so one
// transaction per cycle is sustained while the receiver does not stall. The tick
// that ends discharge timing runs a shift-and-add multiplier twice over 24 bits
// and then, for calibration or a nF or uF display, a restoring divider over 56
// bits, one bit per cycle; no new transaction is taken until its result is loaded.
// A pF display or an error skips the divider and is loaded from the evaluation state.
// Reset restores the default register values and a calibration factor of one,
// and leaves the block idle with no result pending. While the receiver stalls, the
// result register holds its transaction and in_stall stays high.
module rc_capacitance_meter_unit
    import rccm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int ADC_BITS   = ADC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [ADC_BITS-1:0]   sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  charge_drive,
    output logic [STATUS_W-1:0]   status,
    output logic [CAP_W-1:0]      cap_pf,
    output logic [DISP_W-1:0]     display_value,
    output logic [UNIT_W-1:0]     unit
);

    localparam int PRODW = COUNT_BITS + PPT_W;
    localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_CHARGE    = 2'd1;
    localparam logic [1:0] PH_DISCHARGE = 2'd2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_A = 3'd1;
    localparam logic [2:0] ST_MUL_B = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(PPT_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

    logic [THR_W-1:0]      high_thr_reg;
    logic [THR_W-1:0]      low_thr_reg;
    logic [PPT_W-1:0]      ppt_reg;
    logic [REF_W-1:0]      ref_reg;
    logic [CALIB_W-1:0]    calib_reg, calib_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  calibrating_reg, calibrating_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [2:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               res_reg, res_next;
    logic                  out_load;

    logic [PRODW-1:0]      mcand_reg, mcand_next;
    logic [PRODW-1:0]      acc_reg, acc_next;
    logic [PPT_W-1:0]      mpl_reg, mpl_next;
    logic [CAP_W-1:0]      pf_reg, pf_next;
    logic [DIV_W-1:0]      num_reg, num_next;
    logic [CAP_W-1:0]      rem_reg, rem_next;
    logic [CAP_W-1:0]      den_reg, den_next;
    logic [UNIT_W-1:0]     unit_sel_reg, unit_sel_next;

    logic                  accept;
    logic [CMP_W-1:0]      sample_ext;
    logic [CMP_W-1:0]      high_ext;
    logic [CMP_W-1:0]      low_ext;

    logic [PRODW:0]        mul_sum;
    logic [PRODW-1:0]      mul_acc_nx;
    logic [PPT_W-1:0]      mul_mpl_nx;
    logic [PRODW-1:0]      mul_prod_lo;
    logic [PRODW:0]        mul_ext;
    logic [CAP_W-1:0]      pf_sat;

    logic [CAP_W:0]        div_trial;
    logic [CAP_W:0]        div_diff;
    logic                  div_ge;
    logic [CAP_W-1:0]      div_rem_nx;
    logic [DIV_W-1:0]      div_num_nx;
    logic [CALIB_W-1:0]    calib_sat;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign sample_ext = CMP_W'(sample);
    assign high_ext   = CMP_W'(high_thr_reg);
    assign low_ext    = CMP_W'(low_thr_reg);

    assign mul_sum     = {1'b0, acc_reg} + (mpl_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mul_acc_nx  = mul_sum[PRODW:1];
    assign mul_mpl_nx  = {mul_sum[0], mpl_reg[PPT_W-1:1]};
    assign mul_prod_lo = {mul_acc_nx[PRODW-PPT_W-1:0], mul_mpl_nx};
    assign mul_ext     = {1'b0, mul_acc_nx};
    assign pf_sat      = (|mul_ext[PRODW:CAP_W]) ? '1 : mul_acc_nx[CAP_W-1:0];

    assign div_trial  = {rem_reg, num_reg[DIV_W-1]};
    assign div_ge     = div_trial >= {1'b0, den_reg};
    assign div_diff   = div_trial - {1'b0, den_reg};
    assign div_rem_nx = div_ge ? div_diff[CAP_W-1:0] : div_trial[CAP_W-1:0];
    assign div_num_nx = {num_reg[DIV_W-2:0], div_ge};
    assign calib_sat  = (|div_num_nx[DIV_W-1:CALIB_W]) ? '1 : div_num_nx[CALIB_W-1:0];

    always_comb
    begin
        phase_next       = phase_reg;
        calibrating_next = calibrating_reg;
        count_next       = count_reg;
        calib_next       = calib_reg;
        state_next       = state_reg;
        step_next        = step_reg;
        mcand_next       = mcand_reg;
        acc_next         = acc_reg;
        mpl_next         = mpl_reg;
        pf_next          = pf_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        den_next         = den_reg;
        unit_sel_next    = unit_sel_reg;
        out_load         = 1'b0;
        res_next         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_load = 1'b1;
                    unique case (kind)
                        KIND_MEASURE, KIND_CALIBRATE:
                        begin
                            calibrating_next = (kind == KIND_CALIBRATE);
                            phase_next       = PH_CHARGE;
                            count_next       = '0;
                        end
                        KIND_TICK:
                        begin
                            if (phase_reg == PH_CHARGE)
                            begin
                                if (sample_ext >= high_ext)
                                begin
                                    phase_next = PH_DISCHARGE;
                                    count_next = '0;
                                end
                            end
                            else if (phase_reg == PH_DISCHARGE)
                            begin
                                if (sample_ext > low_ext)
                                begin
                                    if (count_reg != '1)
                                    begin
                                        count_next = count_reg + COUNT_BITS'(1);
                                    end
                                end
                                else
                                begin
                                    out_load   = 1'b0;
                                    phase_next = PH_IDLE;
                                    mcand_next = PRODW'(count_reg);
                                    mpl_next   = ppt_reg;
                                    acc_next   = '0;
                                    step_next  = '0;
                                    state_next = ST_MUL_A;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL_A:
            begin
                acc_next  = mul_acc_nx;
                mpl_next  = mul_mpl_nx;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == MUL_LAST)
                begin
                    mcand_next = mul_prod_lo;
                    mpl_next   = PPT_W'(calib_reg);
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                acc_next  = mul_acc_nx;
                mpl_next  = mul_mpl_nx;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == MUL_LAST)
                begin
                    pf_next    = pf_sat;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                rem_next  = '0;
                step_next = '0;
                priority if (pf_reg == '0)
                begin
                    out_load        = 1'b1;
                    res_next.status = STATUS_ERROR;
                    state_next      = ST_IDLE;
                end
                else if (calibrating_reg)
                begin
                    num_next   = {ref_reg, {CAL_FRAC_W{1'b0}}};
                    den_next   = pf_reg;
                    state_next = ST_DIV;
                end
                else if (pf_reg < SCALE_NANO)
                begin
                    out_load               = 1'b1;
                    res_next.status        = STATUS_MEAS_DONE;
                    res_next.cap_pf        = pf_reg;
                    res_next.display_value = pf_reg[DISP_W-1:0];
                    res_next.unit          = UNIT_PF;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    num_next      = DIV_W'(pf_reg);
                    den_next      = (pf_reg < SCALE_MICRO) ? SCALE_NANO : SCALE_MICRO;
                    unit_sel_next = (pf_reg < SCALE_MICRO) ? UNIT_NF : UNIT_UF;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next  = div_num_nx;
                rem_next  = div_rem_nx;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST)
                begin
                    out_load        = 1'b1;
                    res_next.cap_pf = pf_reg;
                    state_next      = ST_IDLE;
                    if (calibrating_reg)
                    begin
                        calib_next      = calib_sat;
                        res_next.status = STATUS_CAL_DONE;
                    end
                    else
                    begin
                        res_next.status        = STATUS_MEAS_DONE;
                        res_next.display_value = div_num_nx[DISP_W-1:0];
                        res_next.unit          = unit_sel_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.charge_drive = (phase_next == PH_CHARGE);
        out_valid_next        = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg    <= HIGH_THR_RST;
            low_thr_reg     <= LOW_THR_RST;
            ppt_reg         <= PPT_RST;
            ref_reg         <= REF_RST;
            calib_reg       <= CALIB_RST;
            phase_reg       <= PH_IDLE;
            calibrating_reg <= 1'b0;
            count_reg       <= '0;
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_HIGH_THR:    high_thr_reg <= cfg_data[THR_W-1:0];
                    REG_LOW_THR:     low_thr_reg  <= cfg_data[THR_W-1:0];
                    REG_PF_PER_TICK: ppt_reg      <= cfg_data[PPT_W-1:0];
                    REG_REFERENCE:   ref_reg      <= cfg_data[REF_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            calib_reg       <= calib_next;
            phase_reg       <= phase_next;
            calibrating_reg <= calibrating_next;
            count_reg       <= count_next;
            state_reg       <= state_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg    <= mcand_next;
        acc_reg      <= acc_next;
        mpl_reg      <= mpl_next;
        pf_reg       <= pf_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        unit_sel_reg <= unit_sel_next;
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign charge_drive  = res_reg.charge_drive;
    assign status        = res_reg.status;
    assign cap_pf        = res_reg.cap_pf;
    assign display_value = res_reg.display_value;
    assign unit          = res_reg.unit;

endmodule

// File: rtl/core/rccm_checker.sv
// Port-level checker of the capacitance meter and the bind that attaches it.
// Depends on rccm_pkg and rc_capacitance_meter_unit_assert.svh.
`include "rc_capacitance_meter_unit_assert.svh"

module rccm_checker
    import rccm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [KIND_W-1:0]   kind,
    input logic                out_valid,
    input logic                out_stall,
    input logic                charge_drive,
    input logic [STATUS_W-1:0] status,
    input logic [CAP_W-1:0]    cap_pf,
    input logic [DISP_W-1:0]   display_value,
    input logic [UNIT_W-1:0]   unit
);

    // A pending result that is held back must block the next transaction.
    `RCCM_ASSERT_IMPLY(a_full_blocks_input, clk, rst_n, out_valid && out_stall, in_stall)

    `RCCM_ASSERT_NEXT(a_start_drives_charge, clk, rst_n, in_valid && !in_stall && (kind == KIND_MEASURE || kind == KIND_CALIBRATE), out_valid && charge_drive && status == STATUS_NONE)

    `RCCM_ASSERT_IMPLY(a_empty_result_fields, clk, rst_n, out_valid && (status == STATUS_NONE || status == STATUS_ERROR), cap_pf == '0 && display_value == '0 && unit == UNIT_PF)

    `RCCM_ASSERT_IMPLY(a_calibration_result, clk, rst_n, out_valid && status == STATUS_CAL_DONE, !charge_drive && cap_pf != '0 && display_value == '0 && unit == UNIT_PF)

endmodule

bind rc_capacitance_meter_unit rccm_checker u_rccm_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench of rc_capacitance_meter_unit: directed and random measurement and calibration
// transactions, each result checked field by field against a predictor of the meter.
// Depends on rccm_pkg and the RTL of the meter; it reads no files.
module testbench;
    import rccm_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int REPORT_LIMIT = 10;
    localparam int ADC_MAX      = (1 << ADC_BITS_DEF) - 1;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [63:0] CAP_MAX    = (64'd1 << CAP_W) - 64'd1;
    localparam logic [63:0] FACTOR_MAX = (64'd1 << CALIB_W) - 64'd1;
    localparam logic [COUNT_BITS_DEF-1:0] TICKS_MAX = '1;
    localparam logic [REF_W-1:0] REF_TOP = 40'd1_000_000_000_000;

    typedef logic [ADC_BITS_DEF-1:0] adc_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef enum logic [1:0] {METER_IDLE, METER_CHARGING, METER_TIMING} meter_phase_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_HIGH_THR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    kind_t                 kind = KIND_TICK;
    adc_t                  sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  charge_drive;
    logic [STATUS_W-1:0]   status;
    logic [CAP_W-1:0]      cap_pf;
    logic [DISP_W-1:0]     display_value;
    logic [UNIT_W-1:0]     unit;

    logic [THR_W-1:0]          high_level = HIGH_THR_RST;
    logic [THR_W-1:0]          low_level = LOW_THR_RST;
    logic [PPT_W-1:0]          pf_per_tick = PPT_RST;
    logic [REF_W-1:0]          reference_cap = REF_RST;
    meter_phase_e              meter_phase = METER_IDLE;
    logic                      cal_run = 1'b0;
    logic [COUNT_BITS_DEF-1:0] ticks = '0;
    logic [CALIB_W-1:0]        cal_factor = CALIB_RST;
    result_t                   awaited_results[$];

    result_t     seen_result;
    result_t     wanted_result;
    bit          quiet_sender = 1'b0;
    bit          quiet_receiver = 1'b0;
    int unsigned stall_span = 0;
    int unsigned useful_items = 0;
    int unsigned mismatch_total = 0;
    int unsigned cycle_count = 0;

    rc_capacitance_meter_unit uut (.*);

    always #5 clk = ~clk;

    function automatic result_t advance_meter(kind_t k, adc_t s);
        result_t    r;
        logic [63:0] product;
        logic [63:0] pf;
        logic [63:0] factor;
        r = '0;
        if (k == KIND_MEASURE || k == KIND_CALIBRATE)
        begin
            cal_run = (k == KIND_CALIBRATE);
            meter_phase = METER_CHARGING;
            ticks = '0;
        end
        else if (k == KIND_TICK)
        begin
            if (meter_phase == METER_CHARGING)
            begin
                if (s >= high_level)
                begin
                    meter_phase = METER_TIMING;
                    ticks = '0;
                end
            end
            else if (meter_phase == METER_TIMING)
            begin
                if (s > low_level)
                begin
                    if (ticks != TICKS_MAX)
                        ticks = ticks + 1'b1;
                end
                else
                begin
                    product = 64'(ticks) * 64'(pf_per_tick);
                    pf = (product >> 24) * 64'(cal_factor)
                        + ((64'(product[23:0]) * 64'(cal_factor)) >> 24);
                    if (pf > CAP_MAX)
                        pf = CAP_MAX;
                    meter_phase = METER_IDLE;
                    if (pf == 64'd0)
                        r.status = STATUS_ERROR;
                    else if (cal_run)
                    begin
                        factor = (64'(reference_cap) << CAL_FRAC_W) / pf;
                        cal_factor = (factor > FACTOR_MAX) ? FACTOR_MAX[CALIB_W-1:0]
                                                           : factor[CALIB_W-1:0];
                        r.status = STATUS_CAL_DONE;
                        r.cap_pf = pf[CAP_W-1:0];
                    end
                    else
                    begin
                        r.status = STATUS_MEAS_DONE;
                        r.cap_pf = pf[CAP_W-1:0];
                        if (pf < 64'(SCALE_NANO))
                        begin
                            r.display_value = pf[DISP_W-1:0];
                            r.unit = UNIT_PF;
                        end
                        else if (pf < 64'(SCALE_MICRO))
                        begin
                            factor = pf / 64'(SCALE_NANO);
                            r.display_value = factor[DISP_W-1:0];
                            r.unit = UNIT_NF;
                        end
                        else
                        begin
                            factor = pf / 64'(SCALE_MICRO);
                            r.display_value = factor[DISP_W-1:0];
                            r.unit = UNIT_UF;
                        end
                    end
                end
            end
        end
        r.charge_drive = (meter_phase == METER_CHARGING);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic adc_t adc_between(int unsigned lo, int unsigned hi);
        return adc_t'($urandom_range(hi, lo));
    endfunction

    task automatic send_item(kind_t k, adc_t s);
        int unsigned gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!(k == KIND_UNUSED || (k == KIND_TICK && meter_phase == METER_IDLE)))
            useful_items++;
        awaited_results.push_back(advance_meter(k, s));
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_HIGH_THR:    high_level = value[THR_W-1:0];
            REG_LOW_THR:     low_level = value[THR_W-1:0];
            REG_PF_PER_TICK: pf_per_tick = value[PPT_W-1:0];
            REG_REFERENCE:   reference_cap = value[REF_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(logic [THR_W-1:0] hi, logic [THR_W-1:0] lo,
                                  logic [PPT_W-1:0] ppt, logic [REF_W-1:0] ref_value);
        wait_results();
        repeat (4) @(negedge clk);
        write_setting(REG_HIGH_THR, CFG_DATA_W'(hi));
        write_setting(REG_LOW_THR, CFG_DATA_W'(lo));
        write_setting(REG_PF_PER_TICK, CFG_DATA_W'(ppt));
        write_setting(REG_REFERENCE, CFG_DATA_W'(ref_value));
        cfg_write <= 1'b0;
    endtask

    task automatic run_fixed_cycle(kind_t start_kind, int unsigned span);
        send_item(start_kind, adc_t'(0));
        send_item(KIND_TICK, adc_t'(ADC_MAX));
        repeat (span) send_item(KIND_TICK, adc_t'(ADC_MAX));
        send_item(KIND_TICK, adc_t'(0));
    endtask

    task automatic run_sequence(bit broken);
        int unsigned stop_at;
        int unsigned span;
        int unsigned roll;
        kind_t       start_kind;
        kind_t       other_kind;
        start_kind = ($urandom_range(3) == 0) ? KIND_CALIBRATE : KIND_MEASURE;
        other_kind = (start_kind == KIND_MEASURE) ? KIND_CALIBRATE : KIND_MEASURE;
        stop_at = broken ? $urandom_range(2) : 3;
        send_item(start_kind, adc_t'($urandom));
        for (int stage = 0; stage < 3; stage++)
        begin
            if (stage == stop_at)
            begin
                if ($urandom_range(1) != 0)
                    send_item(other_kind, adc_t'($urandom));
                return;
            end
            case (stage)
                0:
                begin
                    span = (high_level == 0) ? 0 : $urandom_range(4);
                    repeat (span) send_item(KIND_TICK, adc_between(0, high_level - 1));
                end
                1:
                begin
                    send_item(KIND_TICK, ($urandom_range(3) == 0) ? adc_t'(high_level)
                                                                  : adc_between(high_level, ADC_MAX));
                    roll = $urandom_range(99);
                    if (low_level == THR_W'(ADC_MAX))
                        span = 0;
                    else if (roll < 70)
                        span = $urandom_range(12);
                    else if (roll < 95)
                        span = $urandom_range(60, 13);
                    else
                        span = $urandom_range(300, 61);
                    repeat (span)
                    begin
                        if ($urandom_range(19) == 0)
                            send_item(KIND_UNUSED, adc_t'($urandom));
                        send_item(KIND_TICK, ($urandom_range(3) == 0)
                                                 ? adc_t'(low_level + 1'b1)
                                                 : adc_between(low_level + 1, ADC_MAX));
                    end
                end
                default:
                    send_item(KIND_TICK, ($urandom_range(3) == 0) ? adc_t'(low_level)
                                                                  : adc_between(0, low_level));
            endcase
        end
    endtask

    task automatic note_mismatch(string what, result_t want, result_t got);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT)
        begin
            $display("mismatch at %0t, %s: expected drive %0d status %0d cap %0d disp %0d unit %0d",
                     $time, what, want.charge_drive, want.status, want.cap_pf,
                     want.display_value, want.unit);
            $display("    actual drive %0d status %0d cap %0d disp %0d unit %0d",
                     got.charge_drive, got.status, got.cap_pf, got.display_value, got.unit);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_span == 0 && !quiet_receiver && $urandom_range(99) < 30)
            stall_span = pick_gap();
        if (stall_span != 0)
        begin
            out_stall <= 1'b1;
            stall_span = stall_span - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result = {charge_drive, status, cap_pf, display_value, unit};
            if (awaited_results.size() == 0)
                note_mismatch("unexpected transaction", '0, seen_result);
            else
            begin
                wanted_result = awaited_results.pop_front();
                if (seen_result.charge_drive !== wanted_result.charge_drive
                    || seen_result.status !== wanted_result.status
                    || seen_result.cap_pf !== wanted_result.cap_pf
                    || seen_result.display_value !== wanted_result.display_value
                    || seen_result.unit !== wanted_result.unit)
                    note_mismatch("wrong field", wanted_result, seen_result);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_default_measurement();
        send_item(KIND_TICK, 10'd1023);
        send_item(KIND_UNUSED, 10'd0);
        send_item(KIND_MEASURE, 10'd0);
        send_item(KIND_TICK, 10'd929);
        send_item(KIND_TICK, 10'd930);
        send_item(KIND_TICK, 10'd311);
        send_item(KIND_TICK, 10'd1023);
        send_item(KIND_TICK, 10'd310);
    endtask

    task automatic test_special_cases();
        // A calibration that ends on its first timed tick has a zero count.
        send_item(KIND_CALIBRATE, 10'd0);
        send_item(KIND_TICK, 10'd1023);
        send_item(KIND_TICK, 10'd0);
        // A new start during timing begins again from charging.
        send_item(KIND_MEASURE, 10'd0);
        send_item(KIND_TICK, 10'd1000);
        send_item(KIND_TICK, 10'd500);
        send_item(KIND_CALIBRATE, 10'd1023);
        send_item(KIND_UNUSED, 10'd1023);
        send_item(KIND_TICK, 10'd950);
        send_item(KIND_TICK, 10'd400);
        send_item(KIND_TICK, 10'd100);
    endtask

    task automatic test_threshold_extremes();
        apply_settings(10'd0, 10'd1023, PPT_RST, REF_RST);
        send_item(KIND_MEASURE, 10'd512);
        send_item(KIND_TICK, 10'd0);
        send_item(KIND_TICK, 10'd1023);
        // One tick at the smallest scale rounds to zero picofarads.
        apply_settings(10'd1023, 10'd0, 24'd1, REF_TOP);
        send_item(KIND_CALIBRATE, 10'd0);
        send_item(KIND_TICK, 10'd1023);
        send_item(KIND_TICK, 10'd1);
        send_item(KIND_TICK, 10'd0);
    endtask

    task automatic test_random_sequences();
        int unsigned       target;
        int unsigned       roll;
        logic [THR_W-1:0]  hi_pick;
        logic [THR_W-1:0]  lo_pick;
        logic [PPT_W-1:0]  ppt_pick;
        logic [REF_W-1:0]  ref_pick;
        for (int round = 0; round < 8; round++)
        begin
            if (round == 0)
                apply_settings(HIGH_THR_RST, LOW_THR_RST, PPT_RST, REF_RST);
            else
            begin
                roll = $urandom_range(9);
                hi_pick = (roll == 0) ? THR_W'(ADC_MAX)
                        : (roll == 1) ? THR_W'($urandom_range(50))
                                      : THR_W'($urandom_range(1000, 600));
                roll = $urandom_range(9);
                lo_pick = (roll == 0) ? THR_W'(0)
                        : (roll == 1) ? THR_W'($urandom)
                                      : THR_W'($urandom_range((hi_pick == 0) ? 0 : hi_pick - 1));
                ppt_pick = ($urandom_range(9) == 0) ? '1
                                                    : PPT_W'($urandom >> $urandom_range(31, 8));
                if (ppt_pick == 0)
                    ppt_pick = 24'd1;
                ref_pick = REF_W'(64'd100000 + ({$urandom, $urandom}
                           % (($urandom_range(1) == 0) ? 64'd1_000_000_000
                                                       : 64'd999_999_900_000)));
                apply_settings(hi_pick, lo_pick, ppt_pick, ref_pick);
            end
            quiet_sender = (round % 4 == 3);
            quiet_receiver = (round % 3 == 2);
            target = useful_items + 120;
            while (useful_items < target)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    wait_results();
                if (roll < 80)
                    run_sequence(1'b0);
                else if (roll < 90)
                    run_sequence(1'b1);
                else
                    send_item(kind_t'($urandom), adc_t'($urandom));
            end
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    task automatic test_largest_factor();
        apply_settings(HIGH_THR_RST, LOW_THR_RST, '1, REF_TOP);
        quiet_sender = 1'b1;
        quiet_receiver = 1'b1;
        run_fixed_cycle(KIND_CALIBRATE, 1);
        run_fixed_cycle(KIND_MEASURE, 100);
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    task automatic test_zero_factor();
        apply_settings(HIGH_THR_RST, LOW_THR_RST, '1, REF_TOP);
        run_fixed_cycle(KIND_CALIBRATE, 1);
        apply_settings(HIGH_THR_RST, LOW_THR_RST, '1, 40'd1);
        run_fixed_cycle(KIND_CALIBRATE, 2);
        run_fixed_cycle(KIND_MEASURE, 3);
        run_fixed_cycle(KIND_CALIBRATE, 3);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_measurement();
        test_special_cases();
        test_threshold_extremes();
        test_random_sequences();
        test_largest_factor();
        test_zero_factor();
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_total == 0 && awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
